@@ src/tcw_pkg.sv @@
// Package for the text console writer: cell layout, character codes,
// command codes and the attribute loaded at reset.
// No dependencies.
`timescale 1ns / 1ps

package tcw_pkg;

    // One screen cell: attribute byte above character byte
    typedef struct packed {
        logic [7:0] attr;
        logic [7:0] code;
    } cell_t;

    // Command codes carried on func
    localparam logic [1:0] FUNC_PUT   = 2'd0;
    localparam logic [1:0] FUNC_CLEAR = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;

    // Character codes
    localparam logic [7:0] NEWLINE_CODE = 8'h0A;
    localparam logic [7:0] SPACE_CODE   = 8'h20;

    // Attribute after reset: white on black
    localparam logic [7:0] RESET_COLOR = 8'h0F;

endpackage : tcw_pkg

@@ src/tcw_cell_ram.sv @@
// Screen cell store: one write port and one read port, registered read data.
// Depends on tcw_pkg for the cell layout.
`timescale 1ns / 1ps

module tcw_cell_ram #(
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  tcw_pkg::cell_t           wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output tcw_pkg::cell_t           rdata
);

    tcw_pkg::cell_t mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule : tcw_cell_ram

@@ src/tcw_addr_unit.sv @@
// Shared cell address unit: maps a screen row through the scroll offset onto
// a physical row of the ring and forms row * COLUMNS + column, each step registered.
// No package dependencies.
`timescale 1ns / 1ps

module tcw_addr_unit #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [$clog2(ROWS)-1:0]           row,
    input  logic [$clog2(COLUMNS+1)-1:0]      col,
    input  logic [$clog2(ROWS)-1:0]           base,
    output logic                              done,
    output logic [$clog2(ROWS*COLUMNS)-1:0]   addr
);

    localparam int RW = $clog2(ROWS);
    localparam int CW = $clog2(COLUMNS + 1);
    localparam int AW = $clog2(ROWS * COLUMNS);

    logic          req_v_reg;
    logic          phys_v_reg;
    logic          done_reg;
    logic [RW-1:0] row_reg;
    logic [CW-1:0] col_reg;
    logic [CW-1:0] col1_reg;
    logic [RW-1:0] phys_reg;
    logic [RW-1:0] phys_next;
    logic [RW:0]   row_sum;
    logic [AW-1:0] addr_reg;
    logic [AW-1:0] addr_next;

    // Wrap the screen row onto the ring: sum stays below twice ROWS
    always_comb
    begin
        row_sum = {1'b0, row_reg} + {1'b0, base};
        if (row_sum >= (RW+1)'(ROWS))
        begin
            phys_next = RW'(row_sum - (RW+1)'(ROWS));
        end
        else
        begin
            phys_next = RW'(row_sum);
        end
    end

    // Form the linear cell address
    assign addr_next = (AW'(phys_reg) * AW'(COLUMNS)) + AW'(col1_reg);

    // Stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_v_reg  <= 1'b0;
            phys_v_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            req_v_reg  <= start;
            phys_v_reg <= req_v_reg;
            done_reg   <= phys_v_reg;
        end
    end

    // Stage data
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            row_reg <= row;
            col_reg <= col;
        end
        phys_reg <= phys_next;
        col1_reg <= col_reg;
        addr_reg <= addr_next;
    end

    assign done = done_reg;
    assign addr = addr_reg;

endmodule : tcw_addr_unit

@@ src/text_console_writer.sv @@
// Text console writer top level: command sequencer, cursor, scroll offset
// and colour register. Depends on tcw_pkg, tcw_addr_unit and tcw_cell_ram.
//
//   channel  direction  handshake             payload
//   cfg      in         cfg_valid/cfg_ready   cfg_data (text colour)
//   in       in         in_valid/in_ready     func, char_code, read_row, read_col
//   out      out        out_valid/out_ready   cell_char, cell_color, cursor_row,
//                                             cursor_col
//
// One request at a time; in_ready is low from acceptance until its result is taken.
// Put goes through the address unit and then writes; a newline on a middle row
// only moves the cursor. A newline or wrap on the bottom row first sends the
// new row through the address unit and blanks it (rows sit in a ring, so a
// scroll moves no cells); a wrap then writes the byte. Read: address unit, RAM.
// Clear blanks every cell in the current colour, one cell written per cycle through the
// single write port. After reset a like pass blanks every cell in the reset colour
// with in_ready low; cfg is always ready. A stalled result holds all state but the colour.
`timescale 1ns / 1ps

module text_console_writer #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] func,
    input  logic [7:0] char_code,
    input  logic [4:0] read_row,
    input  logic [6:0] read_col,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] cell_char,
    output logic [7:0] cell_color,
    output logic [4:0] cursor_row,
    output logic [6:0] cursor_col
);

    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);
    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLUMNS + 1);

    typedef enum logic [5:0] {
        S_INIT  = 6'b000001,
        S_IDLE  = 6'b000010,
        S_ADDR  = 6'b000100,
        S_READ  = 6'b001000,
        S_SWEEP = 6'b010000,
        S_OUT   = 6'b100000
    } state_t;

    typedef enum logic [2:0] {
        JOB_WRITE = 3'b001,
        JOB_READ  = 3'b010,
        JOB_BLANK = 3'b100
    } job_t;

    state_t         state_reg, state_next;
    job_t           job_reg, job_next;
    logic           pend_reg, pend_next;
    logic [RW-1:0]  cur_row_reg, cur_row_next;
    logic [CW-1:0]  cur_col_reg, cur_col_next;
    logic [RW-1:0]  base_reg, base_next;
    logic [7:0]     text_color_reg, text_color_next;
    logic [AW-1:0]  sweep_addr_reg, sweep_addr_next;
    logic [AW-1:0]  sweep_cnt_reg, sweep_cnt_next;
    logic [7:0]     char_reg, char_next;
    logic [7:0]     cell_char_reg, cell_char_next;
    logic [7:0]     cell_color_reg, cell_color_next;

    logic           ua_start;
    logic [RW-1:0]  ua_row;
    logic [CW-1:0]  ua_col;
    logic           ua_done;
    logic [AW-1:0]  ua_addr;

    logic           mem_we;
    logic [AW-1:0]  mem_waddr;
    tcw_pkg::cell_t mem_wdata;
    logic           mem_re;
    tcw_pkg::cell_t mem_rdata;

    logic           row_last;
    logic           line_full;
    logic [RW-1:0]  row_inc;
    logic [RW-1:0]  base_inc;
    logic           rd_in_range;

    // Shared address unit
    tcw_addr_unit #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_addr (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ua_start),
        .row   (ua_row),
        .col   (ua_col),
        .base  (base_reg),
        .done  (ua_done),
        .addr  (ua_addr)
    );

    // Screen store
    tcw_cell_ram #(
        .DEPTH (CELLS)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (ua_addr),
        .rdata (mem_rdata)
    );

    // Cursor and ring helpers
    assign row_last    = (cur_row_reg == RW'(ROWS - 1));
    assign line_full   = (cur_col_reg >= CW'(COLUMNS));
    assign row_inc     = cur_row_reg + RW'(1);
    assign base_inc    = (base_reg == RW'(ROWS - 1)) ? '0 : base_reg + RW'(1);
    assign rd_in_range = (int'(read_row) < ROWS) && (int'(read_col) < COLUMNS);

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        job_next        = job_reg;
        pend_next       = pend_reg;
        cur_row_next    = cur_row_reg;
        cur_col_next    = cur_col_reg;
        base_next       = base_reg;
        sweep_addr_next = sweep_addr_reg;
        sweep_cnt_next  = sweep_cnt_reg;
        char_next       = char_reg;
        cell_char_next  = cell_char_reg;
        cell_color_next = cell_color_reg;
        ua_start        = 1'b0;
        ua_row          = cur_row_reg;
        ua_col          = cur_col_reg;
        mem_we          = 1'b0;
        mem_waddr       = sweep_addr_reg;
        mem_wdata.attr  = text_color_reg;
        mem_wdata.code  = tcw_pkg::SPACE_CODE;
        mem_re          = 1'b0;

        unique case (state_reg)
            S_INIT:
            begin
                // Blank every cell with the reset attribute
                mem_we          = 1'b1;
                mem_wdata.attr  = tcw_pkg::RESET_COLOR;
                sweep_addr_next = sweep_addr_reg + AW'(1);
                sweep_cnt_next  = sweep_cnt_reg - AW'(1);
                if (sweep_cnt_reg == '0)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (in_valid)
                begin
                    char_next       = char_code;
                    cell_char_next  = '0;
                    cell_color_next = '0;
                    unique case (func)
                        tcw_pkg::FUNC_PUT:
                        begin
                            if (char_code == tcw_pkg::NEWLINE_CODE)
                            begin
                                cur_col_next = '0;
                                if (!row_last)
                                begin
                                    cur_row_next = row_inc;
                                    state_next   = S_OUT;
                                end
                                else
                                begin
                                    // Scroll: advance the ring, blank the new bottom row
                                    base_next  = base_inc;
                                    ua_start   = 1'b1;
                                    ua_row     = RW'(ROWS - 1);
                                    ua_col     = '0;
                                    job_next   = JOB_BLANK;
                                    pend_next  = 1'b0;
                                    state_next = S_ADDR;
                                end
                            end
                            else if (line_full)
                            begin
                                cur_col_next = '0;
                                if (!row_last)
                                begin
                                    cur_row_next = row_inc;
                                    ua_start     = 1'b1;
                                    ua_row       = row_inc;
                                    ua_col       = '0;
                                    job_next     = JOB_WRITE;
                                    state_next   = S_ADDR;
                                end
                                else
                                begin
                                    // Wrap on the bottom row: scroll, then write
                                    base_next  = base_inc;
                                    ua_start   = 1'b1;
                                    ua_row     = RW'(ROWS - 1);
                                    ua_col     = '0;
                                    job_next   = JOB_BLANK;
                                    pend_next  = 1'b1;
                                    state_next = S_ADDR;
                                end
                            end
                            else
                            begin
                                ua_start   = 1'b1;
                                job_next   = JOB_WRITE;
                                state_next = S_ADDR;
                            end
                        end

                        tcw_pkg::FUNC_CLEAR:
                        begin
                            cur_row_next    = '0;
                            cur_col_next    = '0;
                            base_next       = '0;
                            sweep_addr_next = '0;
                            sweep_cnt_next  = AW'(CELLS - 1);
                            pend_next       = 1'b0;
                            state_next      = S_SWEEP;
                        end

                        tcw_pkg::FUNC_READ:
                        begin
                            if (rd_in_range)
                            begin
                                ua_start   = 1'b1;
                                ua_row     = RW'(read_row);
                                ua_col     = CW'(read_col);
                                job_next   = JOB_READ;
                                state_next = S_ADDR;
                            end
                            else
                            begin
                                state_next = S_OUT;
                            end
                        end

                        default:
                        begin
                            state_next = S_OUT;
                        end
                    endcase
                end
            end

            S_ADDR:
            begin
                if (ua_done)
                begin
                    unique case (job_reg)
                        JOB_WRITE:
                        begin
                            mem_we         = 1'b1;
                            mem_waddr      = ua_addr;
                            mem_wdata.code = char_reg;
                            cur_col_next   = cur_col_reg + CW'(1);
                            state_next     = S_OUT;
                        end
                        JOB_READ:
                        begin
                            mem_re     = 1'b1;
                            state_next = S_READ;
                        end
                        JOB_BLANK:
                        begin
                            sweep_addr_next = ua_addr;
                            sweep_cnt_next  = AW'(COLUMNS - 1);
                            state_next      = S_SWEEP;
                        end
                        default:
                        begin
                            state_next = S_OUT;
                        end
                    endcase
                end
            end

            S_READ:
            begin
                cell_char_next  = mem_rdata.code;
                cell_color_next = mem_rdata.attr;
                state_next      = S_OUT;
            end

            S_SWEEP:
            begin
                // Blank one cell per cycle in the current colour
                mem_we          = 1'b1;
                sweep_addr_next = sweep_addr_reg + AW'(1);
                sweep_cnt_next  = sweep_cnt_reg - AW'(1);
                if (sweep_cnt_reg == '0)
                begin
                    if (pend_reg)
                    begin
                        pend_next  = 1'b0;
                        ua_start   = 1'b1;
                        job_next   = JOB_WRITE;
                        state_next = S_ADDR;
                    end
                    else
                    begin
                        state_next = S_OUT;
                    end
                end
            end

            S_OUT:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Colour register write
    always_comb
    begin
        text_color_next = text_color_reg;
        if (cfg_valid && cfg_ready)
        begin
            text_color_next = cfg_data;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_INIT;
            job_reg        <= JOB_WRITE;
            pend_reg       <= 1'b0;
            cur_row_reg    <= '0;
            cur_col_reg    <= '0;
            base_reg       <= '0;
            text_color_reg <= tcw_pkg::RESET_COLOR;
            sweep_addr_reg <= '0;
            sweep_cnt_reg  <= AW'(CELLS - 1);
        end
        else
        begin
            state_reg      <= state_next;
            job_reg        <= job_next;
            pend_reg       <= pend_next;
            cur_row_reg    <= cur_row_next;
            cur_col_reg    <= cur_col_next;
            base_reg       <= base_next;
            text_color_reg <= text_color_next;
            sweep_addr_reg <= sweep_addr_next;
            sweep_cnt_reg  <= sweep_cnt_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        char_reg       <= char_next;
        cell_char_reg  <= cell_char_next;
        cell_color_reg <= cell_color_next;
    end

    // Ports
    assign cfg_ready  = 1'b1;
    assign in_ready   = (state_reg == S_IDLE);
    assign out_valid  = (state_reg == S_OUT);
    assign cell_char  = cell_char_reg;
    assign cell_color = cell_color_reg;
    assign cursor_row = 5'(cur_row_reg);
    assign cursor_col = 7'(cur_col_reg);

endmodule : text_console_writer

@@ src/tcw_checker.sv @@
// Port checker for the text console writer, bound to the top level.
// Depends only on the top level's ports.
`timescale 1ns / 1ps

module tcw_checker #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [4:0] cursor_row,
    input logic [6:0] cursor_col
);

    // Never take a request while a result is pending
    assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
    else $error("request taken while a result is pending");

    // Drop ready after taking a request
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
    else $error("second request taken before the result");

    // Drop valid once a result has been taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready) |=> !out_valid)
    else $error("result repeated");

    // Hold the reported cursor while the result stalls
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(cursor_row)
                                       && $stable(cursor_col)))
    else $error("stalled result changed");

    // Keep the cursor on the grid (column may sit at line full)
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((ROWS > 32 || int'(cursor_row) < ROWS)
                       && (COLUMNS > 127 || int'(cursor_col) <= COLUMNS)))
    else $error("cursor off the grid");

endmodule : tcw_checker

bind text_console_writer tcw_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tcw_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .cursor_row (cursor_row),
    .cursor_col (cursor_col)
);

@@ dv/text_console_writer_tb.sv @@
// Testbench for text_console_writer: puts, newlines, wraps, scrolls, clears and
// reads checked result by result against a behavioural console held alongside.
// Depends on tcw_pkg and the text_console_writer RTL.
`timescale 1ns / 1ps

module text_console_writer_tb;

    localparam int COL_COUNT = 80;
    localparam int ROW_COUNT = 25;
    localparam logic [1:0] FUNC_SPARE = 2'd3;
    localparam int unsigned REQUEST_TARGET = 1600;
    localparam int unsigned MAX_PRINTED = 40;

    // One result: read cell (zero unless a read hit the grid) and the cursor
    typedef struct packed {
        logic [7:0] code;
        logic [7:0] attr;
        logic [4:0] row;
        logic [6:0] col;
    } console_report_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [7:0] cfg_data = 8'h00;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [1:0] func = tcw_pkg::FUNC_PUT;
    logic [7:0] char_code = 8'h00;
    logic [4:0] read_row = 5'd0;
    logic [6:0] read_col = 7'd0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] cell_char;
    logic [7:0] cell_color;
    logic [4:0] cursor_row;
    logic [6:0] cursor_col;

    // Shadow console: grid, cursor and colour register
    tcw_pkg::cell_t  shadow_screen [ROW_COUNT * COL_COUNT];
    int unsigned     shadow_row;
    int unsigned     shadow_col;
    logic [7:0]      shadow_color;
    console_report_t awaited_reports [$];
    console_report_t oldest_report;

    int unsigned mismatch_count = 0;
    int unsigned requests_sent = 0;
    int unsigned burst_left = 0;

    text_console_writer #(
        .COLUMNS(COL_COUNT),
        .ROWS   (ROW_COUNT)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .func      (func),
        .char_code (char_code),
        .read_row  (read_row),
        .read_col  (read_col),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cell_char (cell_char),
        .cell_color(cell_color),
        .cursor_row(cursor_row),
        .cursor_col(cursor_col)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Fill one row with spaces in the current colour
    function automatic void blank_shadow_row(input int unsigned r);
        for (int c = 0; c < COL_COUNT; c++)
        begin
            shadow_screen[r * COL_COUNT + c].attr = shadow_color;
            shadow_screen[r * COL_COUNT + c].code = tcw_pkg::SPACE_CODE;
        end
    endfunction

    function automatic void blank_shadow_screen();
        for (int r = 0; r < ROW_COUNT; r++)
            blank_shadow_row(r);
        shadow_row = 0;
        shadow_col = 0;
    endfunction

    // Move to the next row; on the bottom row shift the grid up instead
    function automatic void advance_line();
        shadow_col = 0;
        if (shadow_row < ROW_COUNT - 1)
            shadow_row++;
        else
        begin
            for (int i = 0; i < (ROW_COUNT - 1) * COL_COUNT; i++)
                shadow_screen[i] = shadow_screen[i + COL_COUNT];
            blank_shadow_row(ROW_COUNT - 1);
        end
    endfunction

    // Apply one request to the shadow console and return the result it yields
    function automatic console_report_t console_apply(input logic [1:0] f,
                                                      input logic [7:0] ch,
                                                      input logic [4:0] rr,
                                                      input logic [6:0] rc);
        console_report_t rep;
        rep = '0;
        case (f)
            tcw_pkg::FUNC_PUT:
            begin
                if (ch == tcw_pkg::NEWLINE_CODE)
                    advance_line();
                else
                begin
                    // a full line wraps before the byte lands
                    if (shadow_col >= COL_COUNT)
                        advance_line();
                    shadow_screen[shadow_row * COL_COUNT + shadow_col].attr = shadow_color;
                    shadow_screen[shadow_row * COL_COUNT + shadow_col].code = ch;
                    shadow_col++;
                end
            end
            tcw_pkg::FUNC_CLEAR:
                blank_shadow_screen();
            tcw_pkg::FUNC_READ:
            begin
                // reads outside the grid return zeros
                if (rr < ROW_COUNT && rc < COL_COUNT)
                begin
                    rep.code = shadow_screen[rr * COL_COUNT + rc].code;
                    rep.attr = shadow_screen[rr * COL_COUNT + rc].attr;
                end
            end
            default:
                ;
        endcase
        rep.row = 5'(shadow_row);
        rep.col = 7'(shadow_col);
        return rep;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned want,
                                   input int unsigned got);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED)
            $display("%0t: mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
    endtask

    // Send one request, pacing in bursts, and record the result it should give
    task automatic send_request(input logic [1:0] f, input logic [7:0] ch,
                                input logic [4:0] rr, input logic [6:0] rc);
        int unsigned idle_len;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 120)
                                                     : $urandom_range(1, 8);
            idle_len = $urandom_range(0, 6);
            if (idle_len > 0)
            begin
                in_valid <= 1'b0;
                repeat (idle_len) @(posedge clk);
            end
        end
        burst_left--;
        in_valid  <= 1'b1;
        func      <= f;
        char_code <= ch;
        read_row  <= rr;
        read_col  <= rc;
        do
            @(posedge clk);
        while (!in_ready);
        awaited_reports.push_back(console_apply(f, ch, rr, rc));
        requests_sent++;
    endtask

    task automatic put_char(input logic [7:0] ch);
        send_request(tcw_pkg::FUNC_PUT, ch, 5'($urandom), 7'($urandom));
    endtask

    task automatic read_cell(input logic [4:0] rr, input logic [6:0] rc);
        send_request(tcw_pkg::FUNC_READ, 8'($urandom), rr, rc);
    endtask

    task automatic clear_screen();
        send_request(tcw_pkg::FUNC_CLEAR, 8'($urandom), 5'($urandom), 7'($urandom));
    endtask

    // Drop valid and hold until every result is back and the block is ready
    task automatic drain_requests();
        in_valid <= 1'b0;
        burst_left = 0;
        while (awaited_reports.size() != 0 || !in_ready)
            @(posedge clk);
    endtask

    task automatic set_text_color(input logic [7:0] colour);
        drain_requests();
        cfg_valid <= 1'b1;
        cfg_data  <= colour;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        shadow_color = colour;
    endtask

    // Mostly printable text, sometimes any byte but newline
    function automatic logic [7:0] pick_text_byte();
        logic [7:0] b;
        if ($urandom_range(0, 6) != 0)
            b = 8'($urandom_range(8'h20, 8'h7E));
        else
        begin
            b = 8'($urandom_range(0, 255));
            if (b == tcw_pkg::NEWLINE_CODE)
                b = 8'h0B;
        end
        return b;
    endfunction

    // Reset contents, grid corners, reads off the grid, unused command
    task automatic test_reset_contents();
        read_cell(5'd0, 7'd0);
        read_cell(5'(ROW_COUNT - 1), 7'(COL_COUNT - 1));
        read_cell(5'd0, 7'(COL_COUNT - 1));
        read_cell(5'(ROW_COUNT - 1), 7'd0);
        read_cell(5'h1F, 7'h7F);
        read_cell(5'(ROW_COUNT), 7'd5);
        read_cell(5'd3, 7'(COL_COUNT));
        send_request(FUNC_SPARE, 8'hFF, 5'h1F, 7'h7F);
    endtask

    // Byte extremes, newline on a middle row, clear in a new colour
    task automatic test_put_and_clear();
        set_text_color(8'h00);
        put_char(8'h00);
        put_char(8'hFF);
        put_char(8'h41);
        put_char(tcw_pkg::NEWLINE_CODE);
        put_char(8'h7E);
        read_cell(5'd0, 7'd0);
        read_cell(5'd0, 7'd1);
        read_cell(5'd0, 7'd2);
        read_cell(5'd1, 7'd0);
        read_cell(5'd1, 7'd1);
        send_request(FUNC_SPARE, tcw_pkg::NEWLINE_CODE, 5'd0, 7'd0);
        set_text_color(8'hFF);
        clear_screen();
        read_cell(5'd0, 7'd0);
        read_cell(5'(ROW_COUNT - 1), 7'(COL_COUNT - 1));
        put_char(8'h80);
        read_cell(5'd0, 7'd0);
    endtask

    // Fill a line to full, wrap, run to the bottom, then scroll by newline and by wrap
    task automatic test_wrap_and_scroll();
        set_text_color(8'(($urandom_range(0, 15) << 4) | $urandom_range(0, 15)));
        clear_screen();
        repeat (COL_COUNT) put_char(pick_text_byte());
        read_cell(5'd0, 7'(COL_COUNT - 1));
        put_char(pick_text_byte());
        read_cell(5'd1, 7'd0);
        repeat (ROW_COUNT + 3) put_char(tcw_pkg::NEWLINE_CODE);
        read_cell(5'd0, 7'd0);
        read_cell(5'(ROW_COUNT - 1), 7'd0);
        repeat (COL_COUNT) put_char(pick_text_byte());
        put_char(pick_text_byte());
        read_cell(5'(ROW_COUNT - 2), 7'(COL_COUNT - 1));
        read_cell(5'(ROW_COUNT - 1), 7'd0);
        read_cell(5'(ROW_COUNT - 1), 7'd1);
    endtask

    // Phases of random text, newline runs, reads and noise, each in its own colour
    task automatic test_random_text(input int unsigned target);
        int unsigned phase;
        int unsigned phase_end;
        int unsigned pick;
        int unsigned len;
        phase = 0;
        while (requests_sent < target)
        begin
            case (phase)
                0: set_text_color(8'h00);
                1: set_text_color(8'hFF);
                default: set_text_color(8'($urandom_range(0, 255)));
            endcase
            phase_end = requests_sent + 200;
            while (requests_sent < phase_end)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 55)
                begin
                    // a line of text, now and then long enough to wrap
                    len = ($urandom_range(0, 5) == 0) ? $urandom_range(70, 100)
                                                      : $urandom_range(0, 30);
                    repeat (len)
                    begin
                        put_char(pick_text_byte());
                        if ($urandom_range(0, 7) == 0)
                            read_cell(5'(shadow_row), 7'(shadow_col - 1));
                    end
                    if ($urandom_range(0, 9) < 7)
                        put_char(tcw_pkg::NEWLINE_CODE);
                end
                else if (pick < 68)
                begin
                    repeat ($urandom_range(1, 30)) put_char(tcw_pkg::NEWLINE_CODE);
                end
                else if (pick < 86)
                begin
                    repeat ($urandom_range(1, 4))
                    begin
                        if ($urandom_range(0, 1) == 0)
                            read_cell(5'(shadow_row), 7'($urandom_range(0, COL_COUNT - 1)));
                        else
                            read_cell(5'($urandom_range(0, ROW_COUNT - 1)),
                                      7'($urandom_range(0, COL_COUNT - 1)));
                    end
                end
                else if (pick < 94)
                begin
                    // noise: unused command or a read off the grid
                    case ($urandom_range(0, 2))
                        0: send_request(FUNC_SPARE, 8'($urandom), 5'($urandom), 7'($urandom));
                        1: read_cell(5'($urandom_range(ROW_COUNT, 31)),
                                     7'($urandom_range(0, 127)));
                        default: read_cell(5'($urandom_range(0, 31)),
                                           7'($urandom_range(COL_COUNT, 127)));
                    endcase
                end
                else if (pick < 97)
                begin
                    put_char(8'($urandom_range(0, 255)));
                end
                else
                begin
                    clear_screen();
                    read_cell(5'($urandom_range(0, ROW_COUNT - 1)),
                              7'($urandom_range(0, COL_COUNT - 1)));
                end
            end
            phase++;
        end
    endtask

    // Receiver: stall runs of varying length between ready stretches
    initial
    begin : receiver_pacing
        int unsigned stall_len;
        int unsigned ready_len;
        @(posedge clk);
        forever
        begin
            case ($urandom_range(0, 3))
                0:
                begin
                    stall_len = 0;
                    ready_len = $urandom_range(20, 60);
                end
                1:
                begin
                    stall_len = $urandom_range(1, 12);
                    ready_len = 1;
                end
                default:
                begin
                    stall_len = $urandom_range(0, 2);
                    ready_len = $urandom_range(1, 3);
                end
            endcase
            if (stall_len > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall_len) @(posedge clk);
            end
            out_ready <= 1'b1;
            repeat (ready_len) @(posedge clk);
        end
    end

    // Compare each taken result with the oldest one awaited
    always @(posedge clk)
    begin
        if (out_valid && out_ready)
        begin
            if (awaited_reports.size() == 0)
                report_mismatch("unrequested result, cursor_col", 0, cursor_col);
            else
            begin
                oldest_report = awaited_reports.pop_front();
                if (cell_char != oldest_report.code)
                    report_mismatch("cell_char", oldest_report.code, cell_char);
                if (cell_color != oldest_report.attr)
                    report_mismatch("cell_color", oldest_report.attr, cell_color);
                if (cursor_row != oldest_report.row)
                    report_mismatch("cursor_row", oldest_report.row, cursor_row);
                if (cursor_col != oldest_report.col)
                    report_mismatch("cursor_col", oldest_report.col, cursor_col);
            end
        end
    end

    // Run the tests in turn
    initial
    begin
        shadow_color = tcw_pkg::RESET_COLOR;
        blank_shadow_screen();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_contents();
        test_put_and_clear();
        test_wrap_and_scroll();
        test_random_text(REQUEST_TARGET);
        drain_requests();
        repeat (2 * COL_COUNT) @(posedge clk);
        if (awaited_reports.size() != 0)
            report_mismatch("results still awaited", 0, awaited_reports.size());
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Give up after a generous fixed time
    initial
    begin
        #20_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule : text_console_writer_tb
